### rtl/qalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared widths, operation codes and product tables of the quaternion ALU.
// ----------------------------------------------------------------------------
package qalu_pkg;

  // component format, signed Q8.8
  localparam int CW         = 16;
  localparam int FB         = 8;
  // one product, a sum of four products, a sum of four squares
  localparam int PROD_W     = 2 * CW;
  localparam int ACC_W      = PROD_W + 2;
  localparam int DEN_W      = PROD_W + 1;
  // rounding adder for the product path
  localparam int RND_W      = ACC_W + 1;
  // quotient with one guard bit for rounding, and the step pipeline depth
  localparam int QUO_W      = CW + 2;
  localparam int DIV_SHIFT  = QUO_W - FB - 1;
  localparam int PIPE_DEPTH = QUO_W;
  // square root: radicand padded to two bits per step
  localparam int SQ_RAD_W   = 2 * PIPE_DEPTH;
  localparam int SQ_REM_W   = PIPE_DEPTH + 2;
  localparam int NORM_W     = CW + 1;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(FB == 0 ? 0 : (1 << (FB - 1)));

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2,
    OP_NORM = 2'd3
  } op_e;

  // destination component of a[y]*b[x], entry y*4+x
  localparam logic [1:0] PROD_DST_TBL [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd3, 2'd0, 2'd1,
    2'd3, 2'd2, 2'd1, 2'd0
  };
  // sign flip of a[y]*b[x] in the Hamilton product, bit y*4+x
  localparam logic [15:0] PROD_NEG_TBL = 16'hC6A0;
  // sign flip of term y of component d in A*conj(B), bit d*4+y
  localparam logic [15:0] DIV_NEG_TBL  = 16'h3950;

  // data carried beside the divider and square root pipelines
  typedef struct packed {
    op_e                 op;
    logic [3:0][CW-1:0]  comp;
    logic                ovf;
    logic                dz;
  } side_t;

endpackage
`default_nettype wire

### rtl/qalu_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_lane
// One product lane: four signed products, then their signed sum.
// ----------------------------------------------------------------------------
module qalu_lane (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [3:0][qalu_pkg::CW-1:0] opa_i,
  input  wire logic signed [3:0][qalu_pkg::CW-1:0] opb_i,
  input  wire logic [3:0]                        neg_i,
  output      logic signed [qalu_pkg::ACC_W-1:0]  acc_o
);

  logic signed [qalu_pkg::PROD_W-1:0] prod_d [4];
  logic signed [qalu_pkg::PROD_W-1:0] prod_q [4];
  logic [3:0]                         neg_q;
  logic signed [qalu_pkg::ACC_W-1:0]  acc_d;
  logic signed [qalu_pkg::ACC_W-1:0]  acc_q;

  // multiplier row
  always_comb begin
    for (int y = 0; y < 4; y++) begin
      prod_d[y] = qalu_pkg::PROD_W'($signed(opa_i[y]) * $signed(opb_i[y]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      neg_q  <= neg_i;
    end
  end

  // signed sum of the four products
  always_comb begin
    acc_d = '0;
    for (int y = 0; y < 4; y++) begin
      if (neg_q[y]) begin
        acc_d = acc_d - qalu_pkg::ACC_W'(prod_q[y]);
      end else begin
        acc_d = acc_d + qalu_pkg::ACC_W'(prod_q[y]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

### rtl/qalu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_div
// Pipelined restoring divider: one quotient bit per stage, rounded to
// nearest with ties away from zero, saturated to the component range.
// ----------------------------------------------------------------------------
module qalu_div (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic signed [qalu_pkg::ACC_W-1:0]  num_i,
  input  wire logic [qalu_pkg::DEN_W-1:0]         den_i,
  output      logic signed [qalu_pkg::CW-1:0]     quo_o,
  output      logic                               ovf_o
);

  typedef struct packed {
    logic [qalu_pkg::ACC_W-1:0] rem;
    logic [qalu_pkg::QUO_W-1:0] quo;
    logic [qalu_pkg::QUO_W-1:0] dvd;
    logic [qalu_pkg::DEN_W-1:0] den;
    logic                       neg;
    logic                       big;
  } div_st_t;

  logic [qalu_pkg::DEN_W-1:0] mag;
  div_st_t                    init_st;
  div_st_t                    st_q [qalu_pkg::PIPE_DEPTH];
  div_st_t                    last_st;
  logic [qalu_pkg::QUO_W:0]   rnd_sum;
  logic [qalu_pkg::QUO_W-1:0] rnd;

  // one compare and subtract
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t                    r;
    logic [qalu_pkg::ACC_W-1:0] rem2;
    r    = s;
    rem2 = {s.rem[qalu_pkg::ACC_W-2:0], s.dvd[qalu_pkg::QUO_W-1]};
    r.dvd = {s.dvd[qalu_pkg::QUO_W-2:0], 1'b0};
    if (rem2 >= qalu_pkg::ACC_W'(s.den)) begin
      r.rem = rem2 - qalu_pkg::ACC_W'(s.den);
      r.quo = {s.quo[qalu_pkg::QUO_W-2:0], 1'b1};
    end else begin
      r.rem = rem2;
      r.quo = {s.quo[qalu_pkg::QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // magnitude, upper remainder and early overflow
  always_comb begin
    mag = num_i[qalu_pkg::ACC_W-1] ? qalu_pkg::DEN_W'(-num_i)
                                   : qalu_pkg::DEN_W'(num_i);
    init_st.rem = qalu_pkg::ACC_W'(mag >> qalu_pkg::DIV_SHIFT);
    init_st.quo = '0;
    init_st.dvd = qalu_pkg::QUO_W'(mag) << (qalu_pkg::FB + 1);
    init_st.den = den_i;
    init_st.neg = num_i[qalu_pkg::ACC_W-1];
    init_st.big = (mag >> qalu_pkg::DIV_SHIFT) >= den_i;
  end

  // step pipeline
  for (genvar k = 0; k < qalu_pkg::PIPE_DEPTH; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[k] <= div_step(init_st);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[k] <= div_step(st_q[k-1]);
        end
      end
    end
  end

  // rounding and saturation
  always_comb begin
    last_st = st_q[qalu_pkg::PIPE_DEPTH-1];
    rnd_sum = (qalu_pkg::QUO_W + 1)'(last_st.quo) + 1'b1;
    rnd     = rnd_sum[qalu_pkg::QUO_W:1];
    if (last_st.neg) begin
      ovf_o = last_st.big || (rnd > qalu_pkg::QUO_W'(1 << (qalu_pkg::CW - 1)));
      quo_o = ovf_o ? qalu_pkg::CMIN : qalu_pkg::CW'(-rnd);
    end else begin
      ovf_o = last_st.big || (rnd > qalu_pkg::QUO_W'(qalu_pkg::CMAX));
      quo_o = ovf_o ? qalu_pkg::CMAX : qalu_pkg::CW'(rnd);
    end
  end

endmodule
`default_nettype wire

### rtl/qalu_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module qalu_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [qalu_pkg::DEN_W-1:0]  rad_i,
  output      logic [qalu_pkg::NORM_W-1:0] root_o
);

  typedef struct packed {
    logic [qalu_pkg::SQ_REM_W-1:0]   rem;
    logic [qalu_pkg::PIPE_DEPTH-1:0] root;
    logic [qalu_pkg::SQ_RAD_W-1:0]   rad;
  } sq_st_t;

  sq_st_t init_st;
  sq_st_t st_q [qalu_pkg::PIPE_DEPTH];

  // bring down two radicand bits and try the next root bit
  function automatic sq_st_t sq_step(input sq_st_t s);
    sq_st_t                        r;
    logic [qalu_pkg::SQ_REM_W-1:0] rem2;
    logic [qalu_pkg::SQ_REM_W-1:0] trial;
    rem2  = {s.rem[qalu_pkg::SQ_REM_W-3:0], s.rad[qalu_pkg::SQ_RAD_W-1 -: 2]};
    trial = {s.root, 2'b01};
    r.rad = {s.rad[qalu_pkg::SQ_RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[qalu_pkg::PIPE_DEPTH-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[qalu_pkg::PIPE_DEPTH-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    init_st.rem  = '0;
    init_st.root = '0;
    init_st.rad  = qalu_pkg::SQ_RAD_W'(rad_i);
  end

  // step pipeline
  for (genvar k = 0; k < qalu_pkg::PIPE_DEPTH; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[k] <= sq_step(init_st);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[k] <= sq_step(st_q[k-1]);
        end
      end
    end
  end

  assign root_o = st_q[qalu_pkg::PIPE_DEPTH-1].root[qalu_pkg::NORM_W-1:0];

endmodule
`default_nettype wire

### rtl/quaternion_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_alu
// Quaternion add, Hamilton product, divide and norm on signed Q8.8 parts.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock while the output is not stalled and
// returns one result per transaction, in order. Its registers, in order: the
// multiplier rows, the lane sums, the quotient and root step pipelines
// (one quotient bit per stage) and the output register.
// Four product lanes form the four result components and a fifth lane forms
// the sum of squares used as divisor or as radicand; the merge stage picks
// the result by operation. A stall on the output holds the whole pipeline.
// ----------------------------------------------------------------------------
module quaternion_alu (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output      logic                                  in_stall_o,
  input  wire logic [1:0]                            op_i,
  input  wire logic signed [qalu_pkg::CW-1:0]        a_real_i,
  input  wire logic signed [qalu_pkg::CW-1:0]        a_i_i,
  input  wire logic signed [qalu_pkg::CW-1:0]        a_j_i,
  input  wire logic signed [qalu_pkg::CW-1:0]        a_k_i,
  input  wire logic signed [qalu_pkg::CW-1:0]        b_real_i,
  input  wire logic signed [qalu_pkg::CW-1:0]        b_i_i,
  input  wire logic signed [qalu_pkg::CW-1:0]        b_j_i,
  input  wire logic signed [qalu_pkg::CW-1:0]        b_k_i,
  output      logic                                  out_valid_o,
  input  wire logic                                  out_stall_i,
  output      logic signed [qalu_pkg::CW-1:0]        c_real_o,
  output      logic signed [qalu_pkg::CW-1:0]        c_i_o,
  output      logic signed [qalu_pkg::CW-1:0]        c_j_o,
  output      logic signed [qalu_pkg::CW-1:0]        c_k_o,
  output      logic [qalu_pkg::NORM_W-1:0]           norm_o,
  output      logic                                  divide_by_zero_o,
  output      logic                                  overflow_o
);

  localparam int LAST = qalu_pkg::PIPE_DEPTH - 1;

  logic                                en;
  logic signed [3:0][qalu_pkg::CW-1:0] a_w;
  logic signed [3:0][qalu_pkg::CW-1:0] b_w;
  qalu_pkg::op_e                       op_w;

  logic signed [3:0][qalu_pkg::CW-1:0] lane_b [4];
  logic [3:0]                          lane_neg [4];
  logic signed [3:0][qalu_pkg::CW-1:0] sq_op;
  logic signed [qalu_pkg::ACC_W-1:0]   lane_acc [4];
  logic signed [qalu_pkg::ACC_W-1:0]   sq_acc;

  logic [3:0][qalu_pkg::CW-1:0]        add_d;
  logic [3:0]                          add_ovf_d;
  logic [3:0][qalu_pkg::CW-1:0]        add1_q;
  logic [3:0]                          add_ovf1_q;
  logic [3:0][qalu_pkg::CW-1:0]        add2_q;
  logic [3:0]                          add_ovf2_q;
  qalu_pkg::op_e                       op1_q;
  qalu_pkg::op_e                       op2_q;

  logic [qalu_pkg::DEN_W-1:0]          den;
  qalu_pkg::side_t                     side_d;
  qalu_pkg::side_t                     side_q [qalu_pkg::PIPE_DEPTH];

  logic signed [qalu_pkg::CW-1:0]      quo [4];
  logic [3:0]                          quo_ovf;
  logic [qalu_pkg::NORM_W-1:0]         root;

  logic                                v1_q;
  logic                                v2_q;
  logic [qalu_pkg::PIPE_DEPTH-1:0]     vpipe_q;
  logic                                out_valid_q;

  logic [3:0][qalu_pkg::CW-1:0]        c_d;
  logic [3:0][qalu_pkg::CW-1:0]        c_q;
  logic [qalu_pkg::NORM_W-1:0]         norm_d;
  logic [qalu_pkg::NORM_W-1:0]         norm_q;
  logic                                dz_d;
  logic                                dz_q;
  logic                                ovf_d;
  logic                                ovf_q;

  // pipeline advances unless a finished transaction is held at the output
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  assign a_w  = {a_k_i, a_j_i, a_i_i, a_real_i};
  assign b_w  = {b_k_i, b_j_i, b_i_i, b_real_i};
  assign op_w = qalu_pkg::op_e'(op_i);

  // operand routing into the product lanes from the product tables
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      lane_b[d]   = '0;
      lane_neg[d] = '0;
      for (int y = 0; y < 4; y++) begin
        for (int x = 0; x < 4; x++) begin
          if (qalu_pkg::PROD_DST_TBL[y*4+x] == 2'(d)) begin
            lane_b[d][y] = b_w[x];
            if (op_w == qalu_pkg::OP_DIV) begin
              lane_neg[d][y] = qalu_pkg::DIV_NEG_TBL[d*4+y];
            end else begin
              lane_neg[d][y] = qalu_pkg::PROD_NEG_TBL[y*4+x];
            end
          end
        end
      end
    end
    sq_op = (op_w == qalu_pkg::OP_NORM) ? a_w : b_w;
  end

  for (genvar d = 0; d < 4; d++) begin : g_lane
    qalu_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .opa_i (a_w),
      .opb_i (lane_b[d]),
      .neg_i (lane_neg[d]),
      .acc_o (lane_acc[d])
    );
  end

  // sum of squares: divisor for divide, radicand for norm
  qalu_lane u_sq_lane (
    .clk_i (clk_i),
    .en_i  (en),
    .opa_i (sq_op),
    .opb_i (sq_op),
    .neg_i (4'b0000),
    .acc_o (sq_acc)
  );

  // saturating component add
  always_comb begin
    logic signed [qalu_pkg::CW:0] s;
    for (int d = 0; d < 4; d++) begin
      s = (qalu_pkg::CW + 1)'($signed(a_w[d])) + (qalu_pkg::CW + 1)'($signed(b_w[d]));
      add_ovf_d[d] = s[qalu_pkg::CW] != s[qalu_pkg::CW-1];
      if (add_ovf_d[d]) begin
        add_d[d] = s[qalu_pkg::CW] ? qalu_pkg::CMIN : qalu_pkg::CMAX;
      end else begin
        add_d[d] = s[qalu_pkg::CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      add1_q     <= add_d;
      add_ovf1_q <= add_ovf_d;
      op1_q      <= op_w;
      add2_q     <= add1_q;
      add_ovf2_q <= add_ovf1_q;
      op2_q      <= op1_q;
    end
  end

  // product rounding and side data for the step pipelines
  assign den = qalu_pkg::DEN_W'(sq_acc);

  always_comb begin
    logic signed [qalu_pkg::RND_W-1:0] t;
    logic signed [qalu_pkg::RND_W-1:0] sh;
    logic [3:0]                        mul_ovf;
    logic [3:0][qalu_pkg::CW-1:0]      mul_c;
    for (int d = 0; d < 4; d++) begin
      t  = qalu_pkg::RND_W'(lane_acc[d]) + qalu_pkg::RND_HALF;
      sh = t >>> qalu_pkg::FB;
      if (sh > qalu_pkg::RND_W'(qalu_pkg::CMAX)) begin
        mul_ovf[d] = 1'b1;
        mul_c[d]   = qalu_pkg::CMAX;
      end else if (sh < qalu_pkg::RND_W'(qalu_pkg::CMIN)) begin
        mul_ovf[d] = 1'b1;
        mul_c[d]   = qalu_pkg::CMIN;
      end else begin
        mul_ovf[d] = 1'b0;
        mul_c[d]   = sh[qalu_pkg::CW-1:0];
      end
    end
    side_d.op = op2_q;
    if (op2_q == qalu_pkg::OP_ADD) begin
      side_d.comp = add2_q;
      side_d.ovf  = |add_ovf2_q;
    end else begin
      side_d.comp = mul_c;
      side_d.ovf  = |mul_ovf;
    end
    side_d.dz = (op2_q == qalu_pkg::OP_DIV) && (den == '0);
  end

  for (genvar d = 0; d < 4; d++) begin : g_div
    qalu_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (lane_acc[d]),
      .den_i (den),
      .quo_o (quo[d]),
      .ovf_o (quo_ovf[d])
    );
  end

  qalu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (den),
    .root_o (root)
  );

  // side data delay line matching the step pipelines
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < qalu_pkg::PIPE_DEPTH; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      vpipe_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      vpipe_q     <= {vpipe_q[qalu_pkg::PIPE_DEPTH-2:0], v2_q};
      out_valid_q <= vpipe_q[LAST];
    end
  end

  // merge: pick the result by operation
  always_comb begin
    c_d    = '0;
    norm_d = '0;
    dz_d   = 1'b0;
    ovf_d  = 1'b0;
    unique case (side_q[LAST].op)
      qalu_pkg::OP_ADD, qalu_pkg::OP_MUL: begin
        c_d   = side_q[LAST].comp;
        ovf_d = side_q[LAST].ovf;
      end
      qalu_pkg::OP_DIV: begin
        if (side_q[LAST].dz) begin
          dz_d = 1'b1;
        end else begin
          for (int d = 0; d < 4; d++) begin
            c_d[d] = quo[d];
          end
          ovf_d = |quo_ovf;
        end
      end
      qalu_pkg::OP_NORM: begin
        norm_d = root;
      end
      default: begin
        c_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q    <= c_d;
      norm_q <= norm_d;
      dz_q   <= dz_d;
      ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign c_real_o         = c_q[0];
  assign c_i_o            = c_q[1];
  assign c_j_o            = c_q[2];
  assign c_k_o            = c_q[3];
  assign norm_o           = norm_q;
  assign divide_by_zero_o = dz_q;
  assign overflow_o       = ovf_q;

  // a zero divisor gives zero components and no overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> c_q == '0 && !overflow_o)
    else $error("zero divisor result not cleared");

  // a nonzero norm comes only with cleared components and flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && norm_o != '0 |-> c_q == '0 && !overflow_o && !divide_by_zero_o)
    else $error("norm result mixed with other fields");

  // a held output freezes the whole pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(vpipe_q) && $stable(v1_q) && $stable(v2_q))
    else $error("pipeline moved while output stalled");

  // an accepted transaction reaches the first stage register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1_q)
    else $error("accepted transaction lost");

endmodule
`default_nettype wire
